>>> design/tme_pkg.sv
`timescale 1ns / 1ps
package tme_pkg;
   localparam int DIM        = 4;
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int ACC_WIDTH  = 40;

   typedef enum logic [2:0] {
      OP_IDENTITY  = 3'd0,
      OP_TRANSLATE = 3'd1,
      OP_SCALE     = 3'd2,
      OP_ROTATE    = 3'd3,
      OP_LOAD      = 3'd4,
      OP_MULTIPLY  = 3'd5,
      OP_TRANSFORM = 3'd6,
      OP_READ      = 3'd7
   } opcode_type;

   localparam logic signed [DATA_WIDTH-1:0] ONE_VAL = DATA_WIDTH'(1 << FRAC_BITS);

   function automatic logic signed [DATA_WIDTH-1:0] fix_out(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-1:0] sh;
      sh = acc >>> FRAC_BITS;
      if (sh > ACC_WIDTH'((1 << (DATA_WIDTH-1)) - 1))
         fix_out = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else if (sh < -ACC_WIDTH'(1 << (DATA_WIDTH-1)))
         fix_out = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else
         fix_out = sh[DATA_WIDTH-1:0];
   endfunction
endpackage

>>> design/transform_matrix_engine.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 transform engine, signed Q8.8.
// Request channel (req_*): one request per opcode; tdata carries the fields.
// Response channel (rsp_*): multiply and read give 16 entries row-major,
// transform point gives 4 components; tlast marks the final one.
// One shared 16x16 multiplier forms the operand products; a 40-bit accumulator sums the MAC steps.
// Steps per request, from the accepting edge to the next possible accept:
//   identity, translate, load: accept only. Scale: accept plus 3 multiply steps.
//   Rotate: accept, 9 product steps, 9 write steps.
//   Multiply: accept, then per entry 4 MAC steps and an output step.
//   Transform: accept, then per component 4 MAC steps and an output step.
//   Read: accept, then an output step per entry.
// Each output sits in a register until taken; a stalled receiver simply
// holds the sequencer, so no result is dropped. The request side is not
// ready while a request is in progress.
// Reset (synchronous, active high) sets both matrices to identity.
module transform_matrix_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], x_val[18:3], y_val[34:19], z_val[50:35], w_val[66:51],
   // row_idx[68:67], col_idx[70:69], entry_val[86:71], zero pad to 88
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_row[1:0], out_col[3:2], out_val[19:4]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int DW = tme_pkg::DATA_WIDTH;
   localparam int AW = tme_pkg::ACC_WIDTH;

   typedef enum logic [2:0] {S_IDLE, S_SCALE, S_ROT_MUL, S_ROT_WR, S_MAC, S_OUT}
      state_type;

   state_type state_ff;
   logic [2:0] op_ff;
   logic signed [DW-1:0] x_ff, y_ff, z_ff, w_ff;
   logic signed [DW-1:0] cur_ff [16];
   logic signed [DW-1:0] opd_ff [16];
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] prod_ff [9];
   logic [3:0] idx_ff;   // output entry index row*4+col
   logic [3:0] step_ff;  // k or step counter

   logic signed [DW-1:0] ma, mb;
   logic signed [2*DW-1:0] mp;
   logic [1:0] rr, cc;
   logic [3:0] nxt_idx;

   assign rr = idx_ff[3:2];
   assign cc = idx_ff[1:0];
   assign nxt_idx = idx_ff + 4'd1;
   assign req_tready = (state_ff == S_IDLE);

   // operand select for the shared multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_SCALE: begin
            case (step_ff[1:0])
               2'd0: begin ma = cur_ff[0];  mb = x_ff; end
               2'd1: begin ma = cur_ff[5];  mb = y_ff; end
               default: begin ma = cur_ff[10]; mb = z_ff; end
            endcase
         end
         S_ROT_MUL: begin
            case (step_ff)
               4'd0: begin ma = x_ff; mb = x_ff; end
               4'd1: begin ma = x_ff; mb = y_ff; end
               4'd2: begin ma = x_ff; mb = z_ff; end
               4'd3: begin ma = x_ff; mb = w_ff; end
               4'd4: begin ma = y_ff; mb = y_ff; end
               4'd5: begin ma = y_ff; mb = z_ff; end
               4'd6: begin ma = y_ff; mb = w_ff; end
               4'd7: begin ma = z_ff; mb = z_ff; end
               default: begin ma = z_ff; mb = w_ff; end
            endcase
         end
         S_MAC: begin
            ma = cur_ff[{rr, step_ff[1:0]}];
            if (op_ff == tme_pkg::OP_MULTIPLY)
               mb = opd_ff[{step_ff[1:0], cc}];
            else begin
               case (step_ff[1:0])
                  2'd0: mb = x_ff;
                  2'd1: mb = y_ff;
                  2'd2: mb = z_ff;
                  default: mb = tme_pkg::ONE_VAL;
               endcase
            end
         end
         default: ;
      endcase
   end
   assign mp = ma * mb;

   logic signed [AW-1:0] one2, rot_val;
   assign one2 = AW'(1) <<< (2 * tme_pkg::FRAC_BITS);
   // rotation entry for write step: xx0 xy1 xz2 xw3 yy4 yz5 yw6 zz7 zw8
   always_comb begin
      case (step_ff)
         4'd0: rot_val = one2 - 2 * (prod_ff[4] + prod_ff[7]);
         4'd1: rot_val = 2 * (prod_ff[1] + prod_ff[8]);
         4'd2: rot_val = 2 * (prod_ff[2] - prod_ff[6]);
         4'd3: rot_val = 2 * (prod_ff[1] - prod_ff[8]);
         4'd4: rot_val = one2 - 2 * (prod_ff[0] + prod_ff[7]);
         4'd5: rot_val = 2 * (prod_ff[5] + prod_ff[3]);
         4'd6: rot_val = 2 * (prod_ff[2] + prod_ff[6]);
         4'd7: rot_val = 2 * (prod_ff[5] - prod_ff[3]);
         default: rot_val = one2 - 2 * (prod_ff[0] + prod_ff[4]);
      endcase
   end

   logic [3:0] rot_dst;
   always_comb begin
      case (step_ff)
         4'd0: rot_dst = 4'd0;
         4'd1: rot_dst = 4'd1;
         4'd2: rot_dst = 4'd2;
         4'd3: rot_dst = 4'd4;
         4'd4: rot_dst = 4'd5;
         4'd5: rot_dst = 4'd6;
         4'd6: rot_dst = 4'd8;
         4'd7: rot_dst = 4'd9;
         default: rot_dst = 4'd10;
      endcase
   end

   logic last_out;
   assign last_out = (op_ff == tme_pkg::OP_TRANSFORM) ? (idx_ff[3:2] == 2'd3)
                                                      : (idx_ff == 4'd15);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_tvalid <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            cur_ff[i] <= (i % 5 == 0) ? tme_pkg::ONE_VAL : '0;
            opd_ff[i] <= (i % 5 == 0) ? tme_pkg::ONE_VAL : '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= req_tdata[2:0];
                  x_ff    <= req_tdata[18:3];
                  y_ff    <= req_tdata[34:19];
                  z_ff    <= req_tdata[50:35];
                  w_ff    <= req_tdata[66:51];
                  idx_ff  <= '0;
                  step_ff <= '0;
                  acc_ff  <= '0;
                  case (req_tdata[2:0])
                     tme_pkg::OP_IDENTITY:
                        for (int i = 0; i < 16; i++)
                           cur_ff[i] <= (i % 5 == 0) ? tme_pkg::ONE_VAL : '0;
                     tme_pkg::OP_TRANSLATE: begin
                        cur_ff[3]  <= req_tdata[18:3];
                        cur_ff[7]  <= req_tdata[34:19];
                        cur_ff[11] <= req_tdata[50:35];
                     end
                     tme_pkg::OP_SCALE: state_ff <= S_SCALE;
                     tme_pkg::OP_ROTATE: state_ff <= S_ROT_MUL;
                     tme_pkg::OP_LOAD:
                        opd_ff[{req_tdata[68:67], req_tdata[70:69]}] <=
                           req_tdata[86:71];
                     tme_pkg::OP_READ: begin
                        rsp_tvalid <= 1'b1;
                        rsp_tdata  <= {4'd0, cur_ff[0], 4'd0};
                        rsp_tlast  <= 1'b0;
                        state_ff   <= S_OUT;
                     end
                     default: state_ff <= S_MAC;
                  endcase
               end
            end
            S_SCALE: begin
               case (step_ff[1:0])
                  2'd0: if (x_ff != 0) cur_ff[0]  <= tme_pkg::fix_out(AW'(mp));
                  2'd1: if (y_ff != 0) cur_ff[5]  <= tme_pkg::fix_out(AW'(mp));
                  default: if (z_ff != 0) cur_ff[10] <= tme_pkg::fix_out(AW'(mp));
               endcase
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd2) state_ff <= S_IDLE;
            end
            S_ROT_MUL: begin
               prod_ff[step_ff] <= AW'(mp);
               if (step_ff == 4'd8) begin
                  step_ff  <= '0;
                  state_ff <= S_ROT_WR;
               end else
                  step_ff <= step_ff + 4'd1;
            end
            S_ROT_WR: begin
               cur_ff[rot_dst] <= tme_pkg::fix_out(rot_val);
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd8) begin
                  cur_ff[3] <= '0; cur_ff[7] <= '0; cur_ff[11] <= '0;
                  cur_ff[12] <= '0; cur_ff[13] <= '0; cur_ff[14] <= '0;
                  cur_ff[15] <= tme_pkg::ONE_VAL;
                  state_ff <= S_IDLE;
               end
            end
            S_MAC: begin
               if (step_ff == 4'd3) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= {4'd0, tme_pkg::fix_out(acc_ff + AW'(mp)),
                                 (op_ff == tme_pkg::OP_TRANSFORM) ? 2'd0 : cc, rr};
                  rsp_tlast  <= last_out;
                  acc_ff     <= '0;
                  step_ff    <= '0;
                  state_ff   <= S_OUT;
               end else begin
                  acc_ff  <= acc_ff + AW'(mp);
                  step_ff <= step_ff + 4'd1;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (rsp_tlast) begin
                     rsp_tvalid <= 1'b0;
                     state_ff   <= S_IDLE;
                  end else if (op_ff == tme_pkg::OP_READ) begin
                     idx_ff    <= nxt_idx;
                     rsp_tdata <= {4'd0, cur_ff[nxt_idx], nxt_idx[1:0], nxt_idx[3:2]};
                     rsp_tlast <= (idx_ff == 4'd14);
                  end else begin
                     rsp_tvalid <= 1'b0;
                     idx_ff     <= (op_ff == tme_pkg::OP_TRANSFORM) ?
                                   idx_ff + 4'd4 : nxt_idx;
                     state_ff   <= S_MAC;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
